// ===== hdl/rbp_pkg.sv =====
// Shared types, constants and microcode table of the rotor byte generator.
package rbp_pkg;

  // Pool geometry and rotor bases
  localparam int POOL_LEN  = 17;
  localparam int POOL_AW   = $clog2(POOL_LEN);
  localparam int BYTE_W    = 8;
  localparam int ROT_A_BASE = 0;
  localparam int ROT_B_BASE = 2;
  localparam int ROT_C_BASE = 5;
  localparam int ROT_D_BASE = 10;

  // Position kept modulo lcm(2,3,5,7,17)
  localparam int POS_W     = 12;
  localparam int POS_MOD   = 3570;
  localparam int RES_W     = POS_W + 1;
  localparam int BIT_CNT_W = $clog2(POS_W);

  // Burst length
  localparam int MAX_BURST = 64;
  localparam int CNT_W     = $clog2(MAX_BURST + 1);
  localparam int STEP_W    = $clog2(POOL_LEN);

  // Opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SETPOS = 2'd1;
  localparam logic [1:0] OP_GEN    = 2'd2;

  // Read address selects
  localparam logic [2:0] SEL_A    = 3'd0;
  localparam logic [2:0] SEL_B    = 3'd1;
  localparam logic [2:0] SEL_C    = 3'd2;
  localparam logic [2:0] SEL_D    = 3'd3;
  localparam logic [2:0] SEL_SLOT = 3'd4;

  // Accumulator operations
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // Sequencing modes
  localparam logic [2:0] SEQ_NEXT     = 3'd0;
  localparam logic [2:0] SEQ_DISPATCH = 3'd1;
  localparam logic [2:0] SEQ_STEP     = 3'd2;
  localparam logic [2:0] SEQ_EMIT     = 3'd3;
  localparam logic [2:0] SEQ_BITS     = 3'd4;
  localparam logic [2:0] SEQ_HOME     = 3'd5;

  // Microcode addresses
  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] UPC_FETCH = 3'd0;
  localparam logic [UPC_W-1:0] UPC_RD_AB = 3'd1;
  localparam logic [UPC_W-1:0] UPC_RD_CD = 3'd2;
  localparam logic [UPC_W-1:0] UPC_RD_SL = 3'd3;
  localparam logic [UPC_W-1:0] UPC_UPD   = 3'd4;
  localparam logic [UPC_W-1:0] UPC_EMIT  = 3'd5;
  localparam logic [UPC_W-1:0] UPC_SHIFT = 3'd6;

  // One control word
  typedef struct packed {
    logic             fetch;
    logic [2:0]       rd_a;
    logic [2:0]       rd_b;
    logic [1:0]       acc_op;
    logic             wr_upd;
    logic             emit;
    logic             shift;
    logic [2:0]       seq;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  // Status fed back to the sequencer
  typedef struct packed {
    logic gen_go;
    logic load_go;
    logic step_last;
    logic out_blocked;
    logic burst_last;
    logic bits_last;
  } stat_t;

  // Microcode ROM
  function automatic ctrl_t f_ucode(logic [UPC_W-1:0] upc);
    ctrl_t w;
    w = '{fetch: 1'b0, rd_a: SEL_A, rd_b: SEL_B, acc_op: ACC_NONE, wr_upd: 1'b0,
          emit: 1'b0, shift: 1'b0, seq: SEQ_HOME, target: UPC_FETCH};
    case (upc)
      UPC_FETCH: begin
        w.fetch = 1'b1;
        w.seq   = SEQ_DISPATCH;
      end
      UPC_RD_AB: begin
        w.seq = SEQ_NEXT;
      end
      UPC_RD_CD: begin
        w.rd_a   = SEL_C;
        w.rd_b   = SEL_D;
        w.acc_op = ACC_LOAD;
        w.seq    = SEQ_NEXT;
      end
      UPC_RD_SL: begin
        w.rd_a   = SEL_SLOT;
        w.acc_op = ACC_ADD;
        w.seq    = SEQ_NEXT;
      end
      UPC_UPD: begin
        w.wr_upd = 1'b1;
        w.seq    = SEQ_STEP;
        w.target = UPC_RD_AB;
      end
      UPC_EMIT: begin
        w.emit   = 1'b1;
        w.seq    = SEQ_EMIT;
        w.target = UPC_RD_AB;
      end
      UPC_SHIFT: begin
        w.shift = 1'b1;
        w.seq   = SEQ_BITS;
      end
      default: begin
        w.seq = SEQ_HOME;
      end
    endcase
    return w;
  endfunction

  // (r + 1) mod m, for r < m
  function automatic logic [RES_W-1:0] f_inc_mod(logic [RES_W-1:0] r, logic [RES_W-1:0] m);
    logic [RES_W-1:0] t;
    t = r + RES_W'(1);
    if (t >= m) t = '0;
    return t;
  endfunction

  // (2r + b) mod m, for r < m
  function automatic logic [RES_W-1:0] f_dbl_mod(logic [RES_W-1:0] r, logic b,
                                                 logic [RES_W-1:0] m);
    logic [RES_W-1:0] t;
    t = {r[RES_W-2:0], b};
    if (t >= m) t = t - m;
    return t;
  endfunction

endpackage

// ===== hdl/rotor_byte_prng_core.sv =====
// Top level of the rotor byte generator: datapath around the pool RAM.
//
//  channel | direction | signals
//  --------+-----------+-------------------------------------------------------
//  in      | to core   | in_valid/in_ready, opcode, pool_index, pool_value,
//          |           | start_position, byte_count
//  out     | from core | out_valid/out_ready, random_byte, last_byte,
//          |           | next_position
//
// A pool write is done in the fetch step itself; a position load reduces the
// 12-bit start value one bit per cycle into the position and its residues.
// Each generated byte takes 17 pool updates of 4 microcode steps each, set by
// the two read ports of the pool RAM, plus one emit step.
// The emit step waits while the output register still holds an untaken byte.
// After reset the pool reads as zero through one valid bit per byte.
module rotor_byte_prng_core import rbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [4:0]        pool_index,
  input  logic [7:0]        pool_value,
  input  logic [11:0]       start_position,
  input  logic [6:0]        byte_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        random_byte,
  output logic              last_byte,
  output logic [11:0]       next_position
);

  ctrl_t ctrl;
  stat_t stat;

  // Position and its residues
  logic [POS_W-1:0] pos;
  logic             pm2;
  logic [1:0]       pm3;
  logic [2:0]       pm5;
  logic [2:0]       pm7;
  logic [4:0]       pm17;

  // Working residues of k during a byte
  logic             k2;
  logic [1:0]       k3;
  logic [2:0]       k5;
  logic [2:0]       k7;
  logic [4:0]       k17;

  logic [STEP_W-1:0]    step;
  logic [CNT_W-1:0]     remain;
  logic [POS_W-1:0]     sh;
  logic [BIT_CNT_W-1:0] bcnt;
  logic [BYTE_W-1:0]    acc;

  // Pool RAM and valid bits
  logic [POOL_LEN-1:0] vld;
  logic                va_q;
  logic                vb_q;
  logic                we;
  logic [POOL_AW-1:0]  waddr;
  logic [BYTE_W-1:0]   wdata;
  logic [POOL_AW-1:0]  raddr_a;
  logic [POOL_AW-1:0]  raddr_b;
  logic [BYTE_W-1:0]   qa;
  logic [BYTE_W-1:0]   qb;
  logic [BYTE_W-1:0]   da;
  logic [BYTE_W-1:0]   db;

  logic             in_fire;
  logic             emit_go;
  logic [POS_W-1:0] pos_adv;
  logic             wr_req;

  rbp_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  rbp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (POOL_LEN)
  ) u_pool (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (qa),
    .rdata_b (qb)
  );

  // Request handshake and decode
  assign in_ready = ctrl.fetch;
  assign in_fire  = in_valid & in_ready;
  assign wr_req   = in_fire && (opcode == OP_WRITE) && (32'(pool_index) < POOL_LEN);

  assign stat.gen_go      = in_fire && (opcode == OP_GEN) && (byte_count != '0);
  assign stat.load_go     = in_fire && (opcode == OP_SETPOS);
  assign stat.step_last   = (32'(step) == POOL_LEN - 1);
  assign stat.out_blocked = out_valid & ~out_ready;
  assign stat.burst_last  = (remain == CNT_W'(1));
  assign stat.bits_last   = (32'(bcnt) == POS_W - 1);

  assign emit_go = ctrl.emit & ~stat.out_blocked;

  // Read address selection
  function automatic logic [POOL_AW-1:0] f_addr(logic [2:0] sel, logic a2, logic [1:0] a3,
                                                logic [2:0] a5, logic [2:0] a7,
                                                logic [4:0] a17);
    logic [POOL_AW-1:0] r;
    case (sel)
      SEL_A:    r = POOL_AW'(ROT_A_BASE) + POOL_AW'(a2);
      SEL_B:    r = POOL_AW'(ROT_B_BASE) + POOL_AW'(a3);
      SEL_C:    r = POOL_AW'(ROT_C_BASE) + POOL_AW'(a5);
      SEL_D:    r = POOL_AW'(ROT_D_BASE) + POOL_AW'(a7);
      SEL_SLOT: r = POOL_AW'(a17);
      default:  r = '0;
    endcase
    return r;
  endfunction

  assign raddr_a = f_addr(ctrl.rd_a, k2, k3, k5, k7, k17);
  assign raddr_b = f_addr(ctrl.rd_b, k2, k3, k5, k7, k17);

  // Never-written bytes read as zero
  assign da = va_q ? qa : '0;
  assign db = vb_q ? qb : '0;

  // Write port: host load or slot update
  always_comb begin
    we    = wr_req | ctrl.wr_upd;
    waddr = ctrl.wr_upd ? POOL_AW'(k17) : pool_index[POOL_AW-1:0];
    wdata = ctrl.wr_upd ? acc + {da[BYTE_W-2:0], da[BYTE_W-1]} : pool_value;
  end

  // Position after this byte
  assign pos_adv = POS_W'(f_inc_mod(RES_W'(pos), RES_W'(POS_MOD)));

  // Valid bits and their registered read copies
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
    va_q <= vld[raddr_a];
    vb_q <= vld[raddr_b];
  end

  // Rotor sum accumulator
  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD: acc <= da + db;
      ACC_ADD:  acc <= acc + da + db;
      default:  acc <= acc;
    endcase
  end

  // Position, residues and position load by bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      pm2  <= '0;
      pm3  <= '0;
      pm5  <= '0;
      pm7  <= '0;
      pm17 <= '0;
    end else if (stat.load_go) begin
      pos  <= '0;
      pm2  <= '0;
      pm3  <= '0;
      pm5  <= '0;
      pm7  <= '0;
      pm17 <= '0;
    end else if (ctrl.shift) begin
      pos  <= POS_W'(f_dbl_mod(RES_W'(pos), sh[POS_W-1], RES_W'(POS_MOD)));
      pm2  <= 1'(f_dbl_mod(RES_W'(pm2), sh[POS_W-1], RES_W'(2)));
      pm3  <= 2'(f_dbl_mod(RES_W'(pm3), sh[POS_W-1], RES_W'(3)));
      pm5  <= 3'(f_dbl_mod(RES_W'(pm5), sh[POS_W-1], RES_W'(5)));
      pm7  <= 3'(f_dbl_mod(RES_W'(pm7), sh[POS_W-1], RES_W'(7)));
      pm17 <= 5'(f_dbl_mod(RES_W'(pm17), sh[POS_W-1], RES_W'(POOL_LEN)));
    end else if (emit_go) begin
      pos  <= pos_adv;
      pm2  <= 1'(f_inc_mod(RES_W'(pm2), RES_W'(2)));
      pm3  <= 2'(f_inc_mod(RES_W'(pm3), RES_W'(3)));
      pm5  <= 3'(f_inc_mod(RES_W'(pm5), RES_W'(5)));
      pm7  <= 3'(f_inc_mod(RES_W'(pm7), RES_W'(7)));
      pm17 <= 5'(f_inc_mod(RES_W'(pm17), RES_W'(POOL_LEN)));
    end
  end

  // Load shifter and bit counter
  always_ff @(posedge clk) begin
    if (stat.load_go) begin
      sh   <= start_position;
      bcnt <= '0;
    end else if (ctrl.shift) begin
      sh   <= {sh[POS_W-2:0], 1'b0};
      bcnt <= bcnt + BIT_CNT_W'(1);
    end
  end

  // Working residues, step and burst counters
  always_ff @(posedge clk) begin
    if (stat.gen_go) begin
      k2   <= pm2;
      k3   <= pm3;
      k5   <= pm5;
      k7   <= pm7;
      k17  <= pm17;
      step <= '0;
      if (32'(byte_count) > MAX_BURST) remain <= CNT_W'(MAX_BURST);
      else                             remain <= CNT_W'(byte_count);
    end else if (ctrl.wr_upd) begin
      k2   <= 1'(f_inc_mod(RES_W'(k2), RES_W'(2)));
      k3   <= 2'(f_inc_mod(RES_W'(k3), RES_W'(3)));
      k5   <= 3'(f_inc_mod(RES_W'(k5), RES_W'(5)));
      k7   <= 3'(f_inc_mod(RES_W'(k7), RES_W'(7)));
      k17  <= 5'(f_inc_mod(RES_W'(k17), RES_W'(POOL_LEN)));
      step <= step + STEP_W'(1);
    end else if (emit_go) begin
      k2     <= 1'(f_inc_mod(RES_W'(pm2), RES_W'(2)));
      k3     <= 2'(f_inc_mod(RES_W'(pm3), RES_W'(3)));
      k5     <= 3'(f_inc_mod(RES_W'(pm5), RES_W'(5)));
      k7     <= 3'(f_inc_mod(RES_W'(pm7), RES_W'(7)));
      k17    <= 5'(f_inc_mod(RES_W'(pm17), RES_W'(POOL_LEN)));
      step   <= '0;
      remain <= remain - CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      random_byte   <= acc;
      last_byte     <= stat.burst_last;
      next_position <= pos_adv;
    end
  end

endmodule

// ===== hdl/rbp_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module rbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/rbp_useq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module rbp_useq import rbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;

  // Current control word
  assign ctrl = f_ucode(upc);

  // Next microcode address
  always_comb begin
    case (ctrl.seq)
      SEQ_NEXT:     upc_next = upc + UPC_W'(1);
      SEQ_DISPATCH: begin
        if (stat.gen_go)       upc_next = UPC_RD_AB;
        else if (stat.load_go) upc_next = UPC_SHIFT;
        else                   upc_next = UPC_FETCH;
      end
      SEQ_STEP:     upc_next = stat.step_last ? upc + UPC_W'(1) : ctrl.target;
      SEQ_EMIT: begin
        if (stat.out_blocked)     upc_next = upc;
        else if (stat.burst_last) upc_next = UPC_FETCH;
        else                      upc_next = ctrl.target;
      end
      SEQ_BITS:     upc_next = stat.bits_last ? UPC_FETCH : upc;
      default:      upc_next = UPC_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule
